[hw/rtl/llcp_pkg.sv]
package llcp_pkg;

    // Sizing of stores
    localparam int MAX_LINE       = 4096;
    localparam int MAX_HALF_WIDTH = 32;
    localparam int HIST_DEPTH     = MAX_LINE + 2 * MAX_HALF_WIDTH + 1;
    localparam int LAG_DEPTH      = 2 * MAX_HALF_WIDTH + 1;
    localparam int HIST_AW        = $clog2(HIST_DEPTH);
    localparam int LAG_AW         = $clog2(LAG_DEPTH);

    // Field and register widths
    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 13;
    localparam int HW_W     = 6;
    localparam int SH_W     = 5;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 13;
    localparam int ACC_W    = 58;
    localparam int MAG_W    = 32;
    localparam int OFF_W    = 7;

    // Register reset values
    localparam logic [LEN_W-1:0] LINE_LENGTH_RST = LEN_W'(1024);
    localparam logic [HW_W-1:0]  HALF_WIDTH_RST  = HW_W'(8);
    localparam logic [SH_W-1:0]  LEAK_SHIFT_RST  = SH_W'(20);

    // Register indexes
    typedef enum logic [CFG_AW-1:0] {
        CFG_LINE_LENGTH = 2'd0,
        CFG_HALF_WIDTH  = 2'd1,
        CFG_LEAK_SHIFT  = 2'd2
    } cfg_index_t;

    // Controller to datapath
    typedef struct packed {
        logic in_ready;
        logic in_wr;
        logic clr_wr;
        logic ref_rd;
        logic lag_issue;
        logic k_clr;
        logic rep_abs;
        logic rep_sqr;
        logic rep_sqi;
        logic rep_cmp;
        logic out_load;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_done;
        logic lag_last;
        logic pipe_busy;
        logic eob;
        logic out_busy;
    } ctrl_status_t;

endpackage

[hw/rtl/llcp_ram.sv]
module llcp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word registered
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/llcp_ctrl.sv]
module llcp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  llcp_pkg::ctrl_status_t st,
    output llcp_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_REF     = 10'b0000000100,
        S_LAG     = 10'b0000001000,
        S_DRAIN   = 10'b0000010000,
        S_REP_RD  = 10'b0000100000,
        S_REP_ABS = 10'b0001000000,
        S_REP_SQR = 10'b0010000000,
        S_REP_SQI = 10'b0100000000,
        S_REP_CMP = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_pend_reg, out_pend_next;

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        out_pend_next = out_pend_reg;
        cmd           = '0;
        if (out_pend_reg && !st.out_busy) begin
            cmd.out_load  = 1'b1;
            out_pend_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (st.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.in_ready = !out_pend_reg;
                if (s_valid && !out_pend_reg) begin
                    cmd.in_wr  = 1'b1;
                    state_next = S_REF;
                end
            end
            S_REF: begin
                cmd.ref_rd = 1'b1;
                cmd.k_clr  = 1'b1;
                state_next = S_LAG;
            end
            S_LAG: begin
                cmd.lag_issue = 1'b1;
                if (st.lag_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!st.pipe_busy) begin
                    cmd.k_clr  = 1'b1;
                    state_next = st.eob ? S_REP_RD : S_IDLE;
                end
            end
            S_REP_RD: begin
                state_next = S_REP_ABS;
            end
            S_REP_ABS: begin
                cmd.rep_abs = 1'b1;
                state_next  = S_REP_SQR;
            end
            S_REP_SQR: begin
                cmd.rep_sqr = 1'b1;
                state_next  = S_REP_SQI;
            end
            S_REP_SQI: begin
                cmd.rep_sqi = 1'b1;
                state_next  = S_REP_CMP;
            end
            S_REP_CMP: begin
                cmd.rep_cmp = 1'b1;
                if (st.lag_last) begin
                    out_pend_next = 1'b1;
                    state_next    = S_IDLE;
                end else begin
                    state_next = S_REP_RD;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            out_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            out_pend_reg <= out_pend_next;
        end
    end

endmodule

[hw/rtl/llcp_dp.sv]
module llcp_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  llcp_pkg::ctrl_cmd_t                 cmd,
    output llcp_pkg::ctrl_status_t              st,
    input  logic                                cfg_valid,
    input  logic [llcp_pkg::CFG_AW-1:0]         cfg_index,
    input  logic [llcp_pkg::CFG_DW-1:0]         cfg_data,
    input  logic signed [llcp_pkg::SAMPLE_W-1:0] s_sample_real,
    input  logic signed [llcp_pkg::SAMPLE_W-1:0] s_sample_imag,
    input  logic                                s_end_of_batch,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [llcp_pkg::OFF_W-1:0]   m_peak_offset
);

    localparam int HIST_AW = llcp_pkg::HIST_AW;
    localparam int LAG_AW  = llcp_pkg::LAG_AW;
    localparam int SW      = llcp_pkg::SAMPLE_W;
    localparam int ACC_W   = llcp_pkg::ACC_W;
    localparam int MAG_W   = llcp_pkg::MAG_W;
    localparam int PP_W    = 2 * SW;
    localparam int PROD_W  = PP_W + 1;
    localparam int SUM_W   = ACC_W + 2;
    localparam int POS_W   = HIST_AW + 1;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int LAG_DEPTH_W = llcp_pkg::LAG_DEPTH;
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);
    localparam logic [POS_W-1:0] HIST_N = POS_W'(llcp_pkg::HIST_DEPTH);

    // Leak the accumulator, add the product, saturate
    function automatic logic signed [ACC_W-1:0] leak_add(
        input logic signed [ACC_W-1:0]  a,
        input logic signed [PROD_W-1:0] p,
        input logic [llcp_pkg::SH_W-1:0] s
    );
        logic signed [SUM_W-1:0] v;
        v = SUM_W'(a) - SUM_W'(a >>> s) + SUM_W'(p);
        if (v > SAT_MAX) begin
            v = SAT_MAX;
        end else if (v < SAT_MIN) begin
            v = SAT_MIN;
        end
        return v[ACC_W-1:0];
    endfunction

    // Magnitude of the top part
    function automatic logic [MAG_W-1:0] top_abs(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] t;
        t = a >>> (ACC_W - MAG_W);
        return t[MAG_W-1] ? MAG_W'(-t[MAG_W-1:0]) : t[MAG_W-1:0];
    endfunction

    logic [llcp_pkg::LEN_W-1:0] line_reg;
    logic [llcp_pkg::HW_W-1:0]  d_reg;
    logic [llcp_pkg::SH_W-1:0]  shift_reg;
    logic [HIST_AW-1:0] ptr_reg, clr_cnt_reg, lagpos_reg, ref_addr, lag_start;
    logic [LAG_AW-1:0]  k_reg, k1_reg, k2_reg, best_k_reg, twice_d;
    logic [LAG_DEPTH_W-1:0] acc_ok_reg;
    logic v1_reg, v2_reg, ref_cap_reg, eob_reg, m_valid_reg;
    logic signed [SW-1:0] rr_reg, ri_reg;
    logic signed [PP_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [ACC_W-1:0] ar_reg, ai_reg;
    logic [MAG_W-1:0] absr_reg, absi_reg;
    logic [SQ_W-1:0] sqr_reg, sqi_reg;
    logic [SQ_W:0] best_mag_reg, mag;
    logic signed [llcp_pkg::OFF_W-1:0] off_reg;
    logic [POS_W-1:0] ref_sum, lag_sum;
    logic [HIST_AW-1:0] lagpos_inc;
    logic h_we;
    logic [HIST_AW-1:0] h_waddr, h_raddr;
    logic [2*SW-1:0] h_wdata, h_rdata;
    logic [2*ACC_W-1:0] a_wdata, a_rdata;
    logic [ACC_W-1:0] acc_rq, acc_iq;
    logic signed [SW-1:0] xr, xi;
    logic cfg_clr;

    // Address arithmetic
    always_comb begin
        ref_sum = {1'b0, ptr_reg} + HIST_N - POS_W'(line_reg) - POS_W'(d_reg);
        if (ref_sum >= HIST_N) begin
            ref_sum = ref_sum - HIST_N;
        end
        lag_sum = {1'b0, ptr_reg} + HIST_N - POS_W'({d_reg, 1'b0});
        if (lag_sum >= HIST_N) begin
            lag_sum = lag_sum - HIST_N;
        end
        ref_addr   = ref_sum[HIST_AW-1:0];
        lag_start  = lag_sum[HIST_AW-1:0];
        lagpos_inc = (lagpos_reg == HIST_AW'(llcp_pkg::HIST_DEPTH - 1)) ?
                     '0 : lagpos_reg + HIST_AW'(1);
        twice_d    = LAG_AW'({d_reg, 1'b0});
    end

    // History store
    assign h_we    = cmd.clr_wr | cmd.in_wr;
    assign h_waddr = cmd.clr_wr ? clr_cnt_reg : ptr_reg;
    assign h_wdata = cmd.clr_wr ? '0 : {s_sample_imag, s_sample_real};
    assign h_raddr = cmd.ref_rd ? ref_addr : lagpos_reg;

    llcp_ram #(.WIDTH(2 * SW), .DEPTH(llcp_pkg::HIST_DEPTH)) u_hist (
        .aclk  (aclk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    // Lag accumulators, imag over real
    assign a_wdata = {leak_add(ai_reg, PROD_W'(p_ri_reg) - PROD_W'(p_ir_reg), shift_reg),
                      leak_add(ar_reg, PROD_W'(p_rr_reg) + PROD_W'(p_ii_reg), shift_reg)};

    llcp_ram #(.WIDTH(2 * ACC_W), .DEPTH(llcp_pkg::LAG_DEPTH)) u_acc (
        .aclk  (aclk),
        .we    (v2_reg),
        .waddr (k2_reg),
        .wdata (a_wdata),
        .raddr (k_reg),
        .rdata (a_rdata)
    );

    assign xr     = h_rdata[SW-1:0];
    assign xi     = h_rdata[2*SW-1:SW];
    assign acc_rq = a_rdata[ACC_W-1:0];
    assign acc_iq = a_rdata[2*ACC_W-1:ACC_W];
    assign cfg_clr = cfg_valid && (cfg_index == llcp_pkg::CFG_LINE_LENGTH ||
                                   cfg_index == llcp_pkg::CFG_HALF_WIDTH);
    assign mag    = {1'b0, sqr_reg} + {1'b0, sqi_reg};

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg    <= llcp_pkg::LINE_LENGTH_RST;
            d_reg       <= llcp_pkg::HALF_WIDTH_RST;
            shift_reg   <= llcp_pkg::LEAK_SHIFT_RST;
            ptr_reg     <= '0;
            clr_cnt_reg <= '0;
            k_reg       <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            ref_cap_reg <= 1'b0;
            acc_ok_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // Configuration writes
            if (cfg_valid) begin
                unique case (cfg_index)
                    llcp_pkg::CFG_LINE_LENGTH: begin
                        line_reg <= (cfg_data > llcp_pkg::CFG_DW'(llcp_pkg::MAX_LINE)) ?
                                    llcp_pkg::LEN_W'(llcp_pkg::MAX_LINE) :
                                    llcp_pkg::LEN_W'(cfg_data);
                    end
                    llcp_pkg::CFG_HALF_WIDTH: begin
                        d_reg <= (cfg_data[llcp_pkg::HW_W-1:0] >
                                  llcp_pkg::HW_W'(llcp_pkg::MAX_HALF_WIDTH)) ?
                                 llcp_pkg::HW_W'(llcp_pkg::MAX_HALF_WIDTH) :
                                 cfg_data[llcp_pkg::HW_W-1:0];
                    end
                    llcp_pkg::CFG_LEAK_SHIFT: begin
                        shift_reg <= cfg_data[llcp_pkg::SH_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            // Accumulator valid bits
            if (cfg_clr) begin
                acc_ok_reg <= '0;
            end else if (v2_reg) begin
                acc_ok_reg[k2_reg] <= 1'b1;
            end
            if (cmd.clr_wr) begin
                clr_cnt_reg <= clr_cnt_reg + HIST_AW'(1);
            end
            // Advance write pointer once the reference read is out
            if (cmd.ref_rd) begin
                ptr_reg <= (ptr_reg == HIST_AW'(llcp_pkg::HIST_DEPTH - 1)) ?
                           '0 : ptr_reg + HIST_AW'(1);
            end
            if (cmd.k_clr) begin
                k_reg <= '0;
            end else if (cmd.lag_issue || cmd.rep_cmp) begin
                k_reg <= k_reg + LAG_AW'(1);
            end
            v1_reg      <= cmd.lag_issue;
            v2_reg      <= v1_reg;
            ref_cap_reg <= cmd.ref_rd;
            // Output word
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.in_wr) begin
            eob_reg <= s_end_of_batch;
        end
        if (cmd.ref_rd) begin
            lagpos_reg <= lag_start;
        end else if (cmd.lag_issue) begin
            lagpos_reg <= lagpos_inc;
        end
        if (ref_cap_reg) begin
            rr_reg <= xr;
            ri_reg <= xi;
        end
        k1_reg <= k_reg;
        k2_reg <= k1_reg;
        // Product stage
        if (v1_reg) begin
            p_rr_reg <= rr_reg * xr;
            p_ii_reg <= ri_reg * xi;
            p_ri_reg <= rr_reg * xi;
            p_ir_reg <= ri_reg * xr;
            ar_reg   <= acc_ok_reg[k1_reg] ? acc_rq : '0;
            ai_reg   <= acc_ok_reg[k1_reg] ? acc_iq : '0;
        end
        // Peak search
        if (cmd.rep_abs) begin
            absr_reg <= acc_ok_reg[k_reg] ? top_abs(acc_rq) : '0;
            absi_reg <= acc_ok_reg[k_reg] ? top_abs(acc_iq) : '0;
        end
        if (cmd.rep_sqr) begin
            sqr_reg <= absr_reg * absr_reg;
        end
        if (cmd.rep_sqi) begin
            sqi_reg <= absi_reg * absi_reg;
        end
        if (cmd.rep_cmp && (k_reg == '0 || mag > best_mag_reg)) begin
            best_mag_reg <= mag;
            best_k_reg   <= k_reg;
        end
        if (cmd.out_load) begin
            off_reg <= llcp_pkg::OFF_W'(best_k_reg) - llcp_pkg::OFF_W'(d_reg);
        end
    end

    assign st.clr_done  = (clr_cnt_reg == HIST_AW'(llcp_pkg::HIST_DEPTH - 1));
    assign st.lag_last  = (k_reg == twice_d);
    assign st.pipe_busy = v1_reg | v2_reg;
    assign st.eob       = eob_reg;
    assign st.out_busy  = m_valid_reg & !m_ready;
    assign m_valid       = m_valid_reg;
    assign m_peak_offset = off_reg;

`ifndef NO_ASSERTIONS
    a_clr_no_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_wr |-> !cmd.in_wr) else $error("sample write during clear pass");
    a_pipe_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |=> v2_reg) else $error("lag pipeline lost a word");
    a_lag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (k2_reg <= twice_d)) else $error("lag index out of range");
`endif

endmodule

[hw/rtl/line_lag_correlation_peak_unit.sv]
// Per sample: write, reference read, one lag a cycle, then a drain of the lag pipe.
// With end_of_batch set, a peak search over every lag follows, then the output word.
// A new sample is taken only in idle, once the last has left the shared lag multiply-accumulate pipe.
// Reset: synchronous, active low; a clearing pass zeroes all 4161 history words,
// with no sample taken meanwhile; configuration writes are taken at any time.
module line_lag_correlation_peak_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [llcp_pkg::CFG_AW-1:0]         cfg_index,
    input  logic [llcp_pkg::CFG_DW-1:0]         cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [llcp_pkg::SAMPLE_W-1:0] s_sample_real,
    input  logic signed [llcp_pkg::SAMPLE_W-1:0] s_sample_imag,
    input  logic                                s_end_of_batch,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [llcp_pkg::OFF_W-1:0]   m_peak_offset
);

    llcp_pkg::ctrl_cmd_t    cmd;
    llcp_pkg::ctrl_status_t st;

    assign cfg_ready = 1'b1;
    assign s_ready   = cmd.in_ready;

    llcp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .st      (st),
        .cmd     (cmd)
    );

    llcp_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .st             (st),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_sample_real  (s_sample_real),
        .s_sample_imag  (s_sample_imag),
        .s_end_of_batch (s_end_of_batch),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_peak_offset  (m_peak_offset)
    );

endmodule
